// ===== design/clipped_line_rasterizer_top_macros.svh =====
// assertion helpers shared by the rasterizer modules
`ifndef CLIPPED_LINE_RASTERIZER_TOP_MACROS_SVH
`define CLIPPED_LINE_RASTERIZER_TOP_MACROS_SVH

// same-cycle implication, quiet during reset
`define CLR_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// next-cycle implication, quiet during reset
`define CLR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== design/clr_pkg.sv =====
package clr_pkg;

  localparam int CFG_W     = 11;
  localparam int CFG_IDX_W = 1;
  localparam int COLOR_W   = 16;

  localparam logic [CFG_IDX_W-1:0] REG_SCREEN_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_SCREEN_HEIGHT = 1'b1;

  localparam logic [CFG_W-1:0] WIDTH_RESET  = 11'd320;
  localparam logic [CFG_W-1:0] HEIGHT_RESET = 11'd240;

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_STEP = 1'b1;

  localparam logic [3:0] OC_LEFT   = 4'd1;
  localparam logic [3:0] OC_RIGHT  = 4'd2;
  localparam logic [3:0] OC_BOTTOM = 4'd4;
  localparam logic [3:0] OC_TOP    = 4'd8;

  localparam int RND_W = 4;
  localparam logic [RND_W-1:0] MAX_ROUNDS = 4'd8;

  typedef struct packed {
    logic load;
    logic step;
    logic start;
    logic mul_step;
    logic div_step;
    logic apply;
    logic fin_ok;
    logic fin_rej;
  } ctl_cmd_t;

  typedef struct packed {
    logic accept;
    logic reject;
    logic mul_last;
    logic div_last;
  } ctl_sts_t;

endpackage

// ===== design/clr_if.sv =====
interface clr_in_if #(parameter int COORD_BITS = 16) ();
  import clr_pkg::*;
  logic                         valid;
  logic                         ready;
  logic                         cmd;
  logic signed [COORD_BITS-1:0] start_x;
  logic signed [COORD_BITS-1:0] start_y;
  logic signed [COORD_BITS-1:0] end_x;
  logic signed [COORD_BITS-1:0] end_y;
  logic [COLOR_W-1:0]           color;

  modport source (output valid, cmd, start_x, start_y, end_x, end_y, color, input ready);
  modport sink (input valid, cmd, start_x, start_y, end_x, end_y, color, output ready);
endinterface

interface clr_out_if #(parameter int SCREEN_BITS = 10) ();
  import clr_pkg::*;
  logic                   valid;
  logic                   ready;
  logic                   line_visible;
  logic                   pixel_valid;
  logic [SCREEN_BITS-1:0] pixel_x;
  logic [SCREEN_BITS-1:0] pixel_y;
  logic [COLOR_W-1:0]     pixel_color;
  logic                   last_pixel;

  modport source (output valid, line_visible, pixel_valid, pixel_x, pixel_y, pixel_color,
                  last_pixel, input ready);
  modport sink (input valid, line_visible, pixel_valid, pixel_x, pixel_y, pixel_color,
                last_pixel, output ready);
endinterface

// ===== design/clr_ctrl.sv =====
`include "clipped_line_rasterizer_top_macros.svh"

module clr_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic              in_cmd,
  input  logic              out_free,
  input  clr_pkg::ctl_sts_t sts,
  output logic              in_ready,
  output clr_pkg::ctl_cmd_t cmd
);
  import clr_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_EVAL  = 5'b00010,
    S_MUL   = 5'b00100,
    S_DIV   = 5'b01000,
    S_APPLY = 5'b10000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = (state == S_IDLE) && out_free;
    unique case (state)
      S_IDLE: begin
        if (in_valid && in_ready) begin
          if (in_cmd == CMD_STEP) begin
            cmd.step = 1'b1;
          end else begin
            cmd.load   = 1'b1;
            state_next = S_EVAL;
          end
        end
      end
      S_EVAL: begin
        if (sts.reject) begin
          cmd.fin_rej = 1'b1;
          state_next  = S_IDLE;
        end else if (sts.accept) begin
          cmd.fin_ok = 1'b1;
          state_next = S_IDLE;
        end else begin
          cmd.start  = 1'b1;
          state_next = S_MUL;
        end
      end
      S_MUL: begin
        cmd.mul_step = 1'b1;
        if (sts.mul_last) state_next = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) state_next = S_APPLY;
      end
      S_APPLY: begin
        cmd.apply  = 1'b1;
        state_next = S_EVAL;
      end
      default: state_next = S_IDLE;
    endcase
  end

  `CLR_ASSERT(a_ready_only_idle, in_ready |-> (state == S_IDLE), "ready outside idle")
  `CLR_ASSERT_NEXT(a_load_to_eval, cmd.load, state == S_EVAL, "load did not start clipping")
  `CLR_ASSERT_NEXT(a_mul_to_div, (state == S_MUL) && sts.mul_last, state == S_DIV,
                   "multiply did not hand over to divide")

endmodule

// ===== design/clr_datapath.sv =====
`include "clipped_line_rasterizer_top_macros.svh"

module clr_datapath #(
  parameter int COORD_BITS  = 16,
  parameter int SCREEN_BITS = 10
) (
  input  logic                          clk,
  input  logic                          rst,
  input  clr_pkg::ctl_cmd_t             cmd,
  output clr_pkg::ctl_sts_t             sts,
  input  logic                          cfg_wr_en,
  input  logic [clr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [clr_pkg::CFG_W-1:0]     cfg_wr_data,
  input  logic signed [COORD_BITS-1:0]  start_x,
  input  logic signed [COORD_BITS-1:0]  start_y,
  input  logic signed [COORD_BITS-1:0]  end_x,
  input  logic signed [COORD_BITS-1:0]  end_y,
  input  logic [clr_pkg::COLOR_W-1:0]   color,
  input  logic                          out_ready,
  output logic                          out_valid,
  output logic                          line_visible,
  output logic                          pixel_valid,
  output logic [SCREEN_BITS-1:0]        pixel_x,
  output logic [SCREEN_BITS-1:0]        pixel_y,
  output logic [clr_pkg::COLOR_W-1:0]   pixel_color,
  output logic                          last_pixel
);
  import clr_pkg::*;

  localparam int CW  = COORD_BITS + 2;
  localparam int PW  = 2 * CW;
  localparam int CTW = $clog2(PW);
  localparam int LW  = (SCREEN_BITS + 1 > CFG_W) ? SCREEN_BITS + 1 : CFG_W;
  localparam int EW  = SCREEN_BITS + 2;
  localparam logic [LW-1:0] LIM = LW'(1) << SCREEN_BITS;

  function automatic logic [CW-1:0] mag(input logic signed [CW-1:0] v);
    return v[CW-1] ? $unsigned(-v) : $unsigned(v);
  endfunction

  function automatic logic [3:0] outcode(input logic signed [CW-1:0] x,
                                         input logic signed [CW-1:0] y,
                                         input logic signed [CW-1:0] w,
                                         input logic signed [CW-1:0] h);
    logic [3:0] c;
    c = '0;
    if (x < 0) c = c | OC_LEFT;
    else if (x >= w) c = c | OC_RIGHT;
    if (y < 0) c = c | OC_TOP;
    else if (y >= h) c = c | OC_BOTTOM;
    return c;
  endfunction

  // config
  logic [CFG_W-1:0] scr_w, scr_h;

  // clip state
  logic signed [CW-1:0] x0, y0, x1, y1;
  logic [RND_W-1:0]     rnd;
  logic signed [CW-1:0] anchor, bnd;
  logic                 neg, sel_end1, vert;
  logic [PW-1:0]        mcand, prod;
  logic [CW-1:0]        mplier, rem, dvs;
  logic [CTW-1:0]       ctr;

  // walker state
  logic [SCREEN_BITS-1:0] cur_col, cur_row, stop_col, stop_row, span_x, span_y;
  logic signed [EW-1:0]   error_term;
  logic                   dir_x_neg, dir_y_neg, line_active;
  logic [COLOR_W-1:0]     line_colour;

  logic [LW-1:0]        w_eff, h_eff;
  logic signed [CW-1:0] w_s, h_s, dx, dy, bnd_c, anc_c, da_c, t_c, db_c, isect;
  logic [3:0]           c0, c1, csel;
  logic                 is_vert, in_win, both, zero_ext, rnd_out;
  logic [CW:0]          rem_sh, rem_sub;
  logic                 dv_ge;
  logic [CW-1:0]        mdx, mdy;
  logic signed [EW:0]   e2, sx_w, sy_w, err_nx;
  logic                 mv_x, mv_y, at_end;

  always_comb begin
    w_eff = (LW'(scr_w) > LIM) ? LIM : LW'(scr_w);
    h_eff = (LW'(scr_h) > LIM) ? LIM : LW'(scr_h);
    w_s   = $signed(CW'(w_eff));
    h_s   = $signed(CW'(h_eff));
    c0    = outcode(x0, y0, w_s, h_s);
    c1    = outcode(x1, y1, w_s, h_s);
    csel  = (c0 != '0) ? c0 : c1;
    is_vert = (csel & (OC_TOP | OC_BOTTOM)) != '0;
    dx    = x1 - x0;
    dy    = y1 - y0;
    if (is_vert) begin
      bnd_c = ((csel & OC_TOP) != '0) ? '0 : h_s - $signed(CW'(1));
      anc_c = x0;
      da_c  = dx;
      t_c   = bnd_c - y0;
      db_c  = dy;
    end else begin
      bnd_c = ((csel & OC_RIGHT) != '0) ? w_s - $signed(CW'(1)) : '0;
      anc_c = y0;
      da_c  = dy;
      t_c   = bnd_c - x0;
      db_c  = dx;
    end
    in_win   = (c0 | c1) == '0;
    both     = (c0 & c1) != '0;
    zero_ext = (w_eff == '0) || (h_eff == '0);
    rnd_out  = rnd == MAX_ROUNDS;
    sts.accept   = !zero_ext && !rnd_out && in_win;
    sts.reject   = zero_ext || rnd_out || (!in_win && (both || db_c == '0));
    sts.mul_last = ctr == CTW'(CW - 1);
    sts.div_last = ctr == CTW'(PW - 1);

    rem_sh  = {rem, prod[PW-1]};
    dv_ge   = rem_sh >= {1'b0, dvs};
    rem_sub = rem_sh - {1'b0, dvs};
    isect   = neg ? anchor - $signed(prod[CW-1:0]) : anchor + $signed(prod[CW-1:0]);
    mdx     = mag(dx);
    mdy     = mag(dy);

    e2     = {error_term, 1'b0};
    sx_w   = $signed((EW + 1)'(span_x));
    sy_w   = $signed((EW + 1)'(span_y));
    mv_x   = e2 > -sy_w;
    mv_y   = e2 < sx_w;
    err_nx = (EW + 1)'(error_term) - (mv_x ? sy_w : '0) + (mv_y ? sx_w : '0);
    at_end = (cur_col == stop_col) && (cur_row == stop_row);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scr_w       <= WIDTH_RESET;
      scr_h       <= HEIGHT_RESET;
      line_active <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        unique case (cfg_index)
          REG_SCREEN_WIDTH:  scr_w <= cfg_wr_data;
          REG_SCREEN_HEIGHT: scr_h <= cfg_wr_data;
          default: ;
        endcase
      end
      if (out_valid && out_ready) out_valid <= 1'b0;

      if (cmd.load) begin
        x0          <= CW'(start_x);
        y0          <= CW'(start_y);
        x1          <= CW'(end_x);
        y1          <= CW'(end_y);
        line_colour <= color;
        line_active <= 1'b0;
        rnd         <= '0;
      end

      if (cmd.start) begin
        anchor   <= anc_c;
        bnd      <= bnd_c;
        neg      <= da_c[CW-1] ^ t_c[CW-1] ^ db_c[CW-1];
        sel_end1 <= c0 == '0;
        vert     <= is_vert;
        mcand    <= PW'(mag(da_c));
        mplier   <= mag(t_c);
        dvs      <= mag(db_c);
        prod     <= '0;
        rem      <= '0;
        ctr      <= '0;
      end

      if (cmd.mul_step) begin
        if (mplier[0]) prod <= prod + mcand;
        mcand  <= mcand << 1;
        mplier <= mplier >> 1;
        ctr    <= sts.mul_last ? '0 : ctr + 1'b1;
      end

      if (cmd.div_step) begin
        rem  <= dv_ge ? rem_sub[CW-1:0] : rem_sh[CW-1:0];
        prod <= {prod[PW-2:0], dv_ge};
        ctr  <= sts.div_last ? '0 : ctr + 1'b1;
      end

      if (cmd.apply) begin
        rnd <= rnd + 1'b1;
        if (sel_end1) begin
          x1 <= vert ? isect : bnd;
          y1 <= vert ? bnd : isect;
        end else begin
          x0 <= vert ? isect : bnd;
          y0 <= vert ? bnd : isect;
        end
      end

      if (cmd.fin_ok) begin
        cur_col      <= x0[SCREEN_BITS-1:0];
        cur_row      <= y0[SCREEN_BITS-1:0];
        stop_col     <= x1[SCREEN_BITS-1:0];
        stop_row     <= y1[SCREEN_BITS-1:0];
        span_x       <= mdx[SCREEN_BITS-1:0];
        span_y       <= mdy[SCREEN_BITS-1:0];
        dir_x_neg    <= !(x0 < x1);
        dir_y_neg    <= !(y0 < y1);
        error_term   <= $signed(EW'(mdx[SCREEN_BITS-1:0])) - $signed(EW'(mdy[SCREEN_BITS-1:0]));
        line_active  <= 1'b1;
        out_valid    <= 1'b1;
        line_visible <= 1'b1;
        pixel_valid  <= 1'b0;
        pixel_x      <= '0;
        pixel_y      <= '0;
        pixel_color  <= '0;
        last_pixel   <= 1'b0;
      end

      if (cmd.fin_rej) begin
        out_valid    <= 1'b1;
        line_visible <= 1'b0;
        pixel_valid  <= 1'b0;
        pixel_x      <= '0;
        pixel_y      <= '0;
        pixel_color  <= '0;
        last_pixel   <= 1'b0;
      end

      if (cmd.step) begin
        out_valid    <= 1'b1;
        line_visible <= 1'b0;
        pixel_valid  <= line_active;
        pixel_x      <= line_active ? cur_col : '0;
        pixel_y      <= line_active ? cur_row : '0;
        pixel_color  <= line_active ? line_colour : '0;
        last_pixel   <= line_active && at_end;
        if (line_active) begin
          if (at_end) begin
            line_active <= 1'b0;
          end else begin
            error_term <= err_nx[EW-1:0];
            if (mv_x) cur_col <= dir_x_neg ? cur_col - 1'b1 : cur_col + 1'b1;
            if (mv_y) cur_row <= dir_y_neg ? cur_row - 1'b1 : cur_row + 1'b1;
          end
        end
      end
    end
  end

  `CLR_ASSERT(a_cmd_exclusive, $onehot0(cmd), "datapath commands overlap")
  `CLR_ASSERT_NEXT(a_step_gives_word, cmd.step, out_valid, "step left no output word")
  `CLR_ASSERT_NEXT(a_reject_clears_line, cmd.fin_rej, out_valid && !line_active && !line_visible,
                   "rejected load left a line armed")

endmodule

// ===== design/clipped_line_rasterizer_top.sv =====
// channel    dir  word
// in_ch      in   cmd, start_x, start_y, end_x, end_y, color
// out_ch     out  line_visible, pixel_valid, pixel_x, pixel_y, pixel_color, last_pixel
// cfg        in   cfg_wr_en, cfg_index, cfg_wr_data (screen_width, screen_height)
//
// step word: one pixel per cycle while out_ch keeps up
// load word: 0 to 8 clip rounds, each run by the shift-add multiplier and
//   restoring divider, one bit per cycle
// one result word per input word, held in an output register until taken
// sync reset: config back to 320 x 240, no line armed, output empty
module clipped_line_rasterizer_top #(
  parameter int COORD_BITS  = 16,
  parameter int SCREEN_BITS = 10
) (
  input  logic                          clk,
  input  logic                          rst,
  clr_in_if.sink                        in_ch,
  clr_out_if.source                     out_ch,
  input  logic                          cfg_wr_en,
  input  logic [clr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [clr_pkg::CFG_W-1:0]     cfg_wr_data
);
  import clr_pkg::*;

  ctl_cmd_t cmd;
  ctl_sts_t sts;
  logic     out_free;
  logic     in_ready;

  assign out_free    = !out_ch.valid || out_ch.ready;
  assign in_ch.ready = in_ready;

  clr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_ch.valid),
    .in_cmd   (in_ch.cmd),
    .out_free (out_free),
    .sts      (sts),
    .in_ready (in_ready),
    .cmd      (cmd)
  );

  clr_datapath #(
    .COORD_BITS  (COORD_BITS),
    .SCREEN_BITS (SCREEN_BITS)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .sts          (sts),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_index    (cfg_index),
    .cfg_wr_data  (cfg_wr_data),
    .start_x      (in_ch.start_x),
    .start_y      (in_ch.start_y),
    .end_x        (in_ch.end_x),
    .end_y        (in_ch.end_y),
    .color        (in_ch.color),
    .out_ready    (out_ch.ready),
    .out_valid    (out_ch.valid),
    .line_visible (out_ch.line_visible),
    .pixel_valid  (out_ch.pixel_valid),
    .pixel_x      (out_ch.pixel_x),
    .pixel_y      (out_ch.pixel_y),
    .pixel_color  (out_ch.pixel_color),
    .last_pixel   (out_ch.last_pixel)
  );

endmodule

// ===== verif/clr_line_checker.sv =====
`timescale 1ns / 1ps

module clr_line_checker
  import clr_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  clr_in_if                    in_ch,
  clr_out_if                   out_ch,
  input  logic                 cfg_wr_en,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wr_data,
  output int                   errors,
  output int                   pending,
  output int                   loads_seen,
  output int                   visible_seen,
  output int                   pixels_seen
);

  typedef struct packed {
    logic         vis;
    logic         pv;
    logic [9:0]   px;
    logic [9:0]   py;
    logic [15:0]  pc;
    logic         last;
  } pixel_word_t;

  pixel_word_t pixel_q[$];

  logic [CFG_W-1:0] scr_w, scr_h;
  logic [9:0]  col, row, stop_col, stop_row, dx_abs, dy_abs;
  int          err_acc;
  logic        x_back, y_back, armed;
  logic [15:0] ink;
  longint      cx0, cy0, cx1, cy1;

  function automatic logic [3:0] region(longint x, longint y, longint w, longint h);
    logic [3:0] c;
    c = 4'd0;
    if (x < 0) c |= OC_LEFT;
    else if (x >= w) c |= OC_RIGHT;
    if (y < 0) c |= OC_TOP;
    else if (y >= h) c |= OC_BOTTOM;
    return c;
  endfunction

  function automatic bit clip_to_screen(longint w, longint h);
    logic [3:0] c0, c1, c;
    longint x, y, dx, dy;
    c0 = region(cx0, cy0, w, h);
    c1 = region(cx1, cy1, w, h);
    for (int r = 0; r < 8; r++) begin
      if ((c0 | c1) == 4'd0) return 1'b1;
      if ((c0 & c1) != 4'd0) return 1'b0;
      c = (c0 != 4'd0) ? c0 : c1;
      dx = cx1 - cx0;
      dy = cy1 - cy0;
      if ((c & (OC_TOP | OC_BOTTOM)) != 4'd0) begin
        if (dy == 0) return 1'b0;
        y = ((c & OC_TOP) != 4'd0) ? 0 : h - 1;
        x = cx0 + (dx * (y - cy0)) / dy;
      end else begin
        if (dx == 0) return 1'b0;
        x = ((c & OC_RIGHT) != 4'd0) ? w - 1 : 0;
        y = cy0 + (dy * (x - cx0)) / dx;
      end
      if (c == c0) begin
        cx0 = x; cy0 = y; c0 = region(x, y, w, h);
      end else begin
        cx1 = x; cy1 = y; c1 = region(x, y, w, h);
      end
    end
    return 1'b0;
  endfunction

  function automatic pixel_word_t next_pixel_word(logic cmd, logic signed [15:0] sx,
      logic signed [15:0] sy, logic signed [15:0] ex, logic signed [15:0] ey,
      logic [15:0] c);
    pixel_word_t res;
    longint w, h;
    int e2;
    res = '0;
    if (cmd == CMD_LOAD) begin
      w = (scr_w > 1024) ? 1024 : scr_w;
      h = (scr_h > 1024) ? 1024 : scr_h;
      cx0 = sx; cy0 = sy; cx1 = ex; cy1 = ey;
      armed = 1'b0;
      loads_seen++;
      if (w == 0 || h == 0 || !clip_to_screen(w, h)) return res;
      col      = cx0[9:0];
      row      = cy0[9:0];
      stop_col = cx1[9:0];
      stop_row = cy1[9:0];
      dx_abs   = (cx1 >= cx0) ? 10'(cx1 - cx0) : 10'(cx0 - cx1);
      dy_abs   = (cy1 >= cy0) ? 10'(cy1 - cy0) : 10'(cy0 - cy1);
      x_back   = !(cx0 < cx1);
      y_back   = !(cy0 < cy1);
      err_acc  = int'(dx_abs) - int'(dy_abs);
      ink      = c;
      armed    = 1'b1;
      res.vis  = 1'b1;
      visible_seen++;
      return res;
    end
    if (!armed) return res;
    pixels_seen++;
    res.pv = 1'b1;
    res.px = col;
    res.py = row;
    res.pc = ink;
    if (col == stop_col && row == stop_row) begin
      res.last = 1'b1;
      armed = 1'b0;
      return res;
    end
    e2 = 2 * err_acc;
    if (e2 > -int'(dy_abs)) begin
      err_acc -= int'(dy_abs);
      col = x_back ? col - 10'd1 : col + 10'd1;
    end
    if (e2 < int'(dx_abs)) begin
      err_acc += int'(dx_abs);
      row = y_back ? row - 10'd1 : row + 10'd1;
    end
    return res;
  endfunction

  initial begin
    errors = 0; pending = 0; loads_seen = 0; visible_seen = 0; pixels_seen = 0;
  end

  always @(posedge clk) begin
    pixel_word_t got, want;
    if (rst) begin
      scr_w = WIDTH_RESET; scr_h = HEIGHT_RESET;
      col = '0; row = '0; stop_col = '0; stop_row = '0; dx_abs = '0; dy_abs = '0;
      err_acc = 0; x_back = 0; y_back = 0; armed = 0; ink = '0;
      pixel_q.delete();
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          REG_SCREEN_WIDTH:  scr_w = cfg_wr_data;
          REG_SCREEN_HEIGHT: scr_h = cfg_wr_data;
          default: ;
        endcase
      end
      if (in_ch.valid && in_ch.ready)
        pixel_q.push_back(next_pixel_word(in_ch.cmd, in_ch.start_x, in_ch.start_y,
                                          in_ch.end_x, in_ch.end_y, in_ch.color));
      if (out_ch.valid && out_ch.ready) begin
        got = '{out_ch.line_visible, out_ch.pixel_valid, out_ch.pixel_x, out_ch.pixel_y,
                out_ch.pixel_color, out_ch.last_pixel};
        if (pixel_q.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected word: vis %0b pv %0b (%0d,%0d) c %h last %0b",
                                     got.vis, got.pv, got.px, got.py, got.pc, got.last);
        end else begin
          want = pixel_q.pop_front();
          if (got !== want) begin
            errors++;
            if (errors <= 10)
              $display("mismatch: exp vis %0b pv %0b (%0d,%0d) c %h last %0b, got vis %0b pv %0b (%0d,%0d) c %h last %0b",
                       want.vis, want.pv, want.px, want.py, want.pc, want.last,
                       got.vis, got.pv, got.px, got.py, got.pc, got.last);
          end
        end
      end
    end
    pending = pixel_q.size();
  end

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
  import clr_pkg::*;

  localparam int SETTLE = 240;
  localparam int CYCLE_LIMIT = 2000000;

  logic clk, rst;
  logic                 cfg_wr_en;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_wr_data;
  bit                   calm;
  int                   stall_left, cycles, errors, pending;
  int                   loads_seen, visible_seen, pixels_seen, sizes_seen;

  clr_in_if  in_ch ();
  clr_out_if out_ch ();

  clipped_line_rasterizer_top i_dut (
    .clk(clk), .rst(rst), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wr_data(cfg_wr_data)
  );

  clr_line_checker i_checker (
    .clk(clk), .rst(rst), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wr_data(cfg_wr_data),
    .errors(errors), .pending(pending), .loads_seen(loads_seen),
    .visible_seen(visible_seen), .pixels_seen(pixels_seen)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_top: FAIL");
      $finish;
    end
  end

  // receiver stalls
  always @(posedge clk) begin
    if (rst) begin
      out_ch.ready <= 1'b0;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ch.ready <= 1'b0;
    end else if (!calm && $urandom_range(0, 11) == 0) begin
      stall_left <= $urandom_range(1, 17) - 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  task automatic send_word(logic cmd, int sx, int sy, int ex, int ey, int c);
    in_ch.valid <= 1'b1;
    in_ch.cmd <= cmd;
    in_ch.start_x <= 16'(sx);
    in_ch.start_y <= 16'(sy);
    in_ch.end_x <= 16'(ex);
    in_ch.end_y <= 16'(ey);
    in_ch.color <= 16'(c);
    do @(posedge clk); while (!in_ch.ready);
    if (!calm && $urandom_range(0, 9) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
  endtask

  task automatic step_word();
    send_word(CMD_STEP, $urandom(), $urandom(), $urandom(), $urandom(), $urandom());
  endtask

  task automatic set_screen(int w, int h);
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= REG_SCREEN_WIDTH;
    cfg_wr_data <= CFG_W'(w);
    @(posedge clk);
    cfg_index <= REG_SCREEN_HEIGHT;
    cfg_wr_data <= CFG_W'(h);
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    sizes_seen++;
  endtask

  task automatic random_phase(int w, int h, int budget);
    int used, n, x0, y0, x1, y1, span;
    used = 0;
    while (used < budget) begin
      if ($urandom_range(0, 99) < 12) begin
        send_word(CMD_LOAD, $urandom(), $urandom(), $urandom(), $urandom(), $urandom());
      end else if ($urandom_range(0, 99) < 5) begin
        step_word();
      end else begin
        span = ($urandom_range(0, 9) == 0) ? 200 : 30;
        x0 = $urandom_range(0, w + 80) - 40;
        y0 = $urandom_range(0, h + 80) - 40;
        x1 = x0 + $urandom_range(0, 2 * span) - span;
        y1 = y0 + $urandom_range(0, 2 * span) - span;
        send_word(CMD_LOAD, x0, y0, x1, y1, $urandom());
      end
      n = $urandom_range(1, 45);
      repeat (n) step_word();
      used += n + 1;
    end
  endtask

  initial begin
    int ws[10], hs[10];
    ws = '{320, 1, 1024, 2047, 0, 320, 17, 1000, 0, 0};
    hs = '{240, 1, 1024, 2047, 240, 0, 900, 3, 0, 0};
    ws[8] = $urandom_range(1, 2047); hs[8] = $urandom_range(1, 2047);
    ws[9] = $urandom_range(1, 200);  hs[9] = $urandom_range(1, 200);
    cycles = 0; calm = 0; sizes_seen = 0;
    rst <= 1'b1;
    cfg_wr_en <= 1'b0; cfg_index <= REG_SCREEN_WIDTH; cfg_wr_data <= '0;
    in_ch.valid <= 1'b0; in_ch.cmd <= CMD_LOAD;
    in_ch.start_x <= '0; in_ch.start_y <= '0; in_ch.end_x <= '0; in_ch.end_y <= '0;
    in_ch.color <= '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    set_screen(320, 240);
    step_word();
    send_word(CMD_LOAD, 0, 0, 319, 239, 16'hffff);
    repeat (3) step_word();
    send_word(CMD_LOAD, 16'h8000, 16'h8000, 16'h7fff, 16'h7fff, 16'h0000);
    repeat (2) step_word();
    send_word(CMD_LOAD, -5, 10, -1, 20, 16'h1234);
    step_word();
    send_word(CMD_LOAD, 5, 5, 5, 5, 16'h5555);
    repeat (2) step_word();
    send_word(CMD_LOAD, 300, 10, 400, 10, 16'haaaa);
    repeat (2) step_word();
    send_word(CMD_LOAD, 10, -100, 10, 5, 16'h0f0f);
    repeat (8) step_word();
    send_word(CMD_LOAD, 16'h8000, 16'h7fff, 16'h7fff, 16'h8000, 16'hf0f0);
    step_word();
    send_word(CMD_LOAD, 330, -20, 250, 260, 16'h00ff);
    step_word();

    for (int p = 0; p < 10; p++) begin
      if (p != 0) set_screen(ws[p], hs[p]);
      if (p == 9) calm = 1;
      random_phase((ws[p] > 1024) ? 1024 : ws[p], (hs[p] > 1024) ? 1024 : hs[p], 165);
    end

    in_ch.valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    $display("covered %0d line loads (%0d on screen) and %0d drawn pixels", loads_seen,
             visible_seen, pixels_seen);
    $display("across %0d screen sizes, including zero and oversized extents", sizes_seen);
    if (errors == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule
